FILE: rtl/gfis_pkg.sv
package gfis_pkg;

    localparam int TABLE_DEPTH_DEF  = 256;
    localparam int POLY_WIDTH_DEF   = 32;
    localparam int SEARCH_LIMIT_DEF = 16 * 16 * 16 * 16 * 16 * 16;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 9;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_FIND = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    typedef struct packed {
        logic               operation;
        logic [VALUE_W-1:0] load_value;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] polynomial;
        logic               found;
        logic [1:0]         status;
        logic [COUNT_W-1:0] entry_count;
    } t_out_item;

    // Status of the bit-serial remainder unit.
    typedef struct packed {
        logic busy;
        logic done;
        logic zero;
    } t_rem_stat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_REPLY
    } t_state;

endpackage

FILE: rtl/gfis_ram.sv
module gfis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/gfis_rem.sv
module gfis_rem #(
    parameter int POLY_WIDTH = gfis_pkg::POLY_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [POLY_WIDTH-1:0] i_dividend,
    input  logic [POLY_WIDTH-1:0] i_divisor,
    output gfis_pkg::t_rem_stat   o_stat
);

    localparam int CNT_W = $clog2(POLY_WIDTH);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [POLY_WIDTH-1:0] r_sh, n_sh;
    logic [POLY_WIDTH-1:0] r_rem, n_rem;
    logic [POLY_WIDTH-1:0] w_shifted;
    logic [POLY_WIDTH-1:0] w_reduced;

    // One dividend bit enters per cycle, MSB first. The shifted remainder
    // still holds the divisor's top bit exactly when xoring the divisor
    // makes it smaller; a zero divisor never reduces anything.
    assign w_shifted = {r_rem[POLY_WIDTH-2:0], r_sh[POLY_WIDTH-1]};
    assign w_reduced = w_shifted ^ i_divisor;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_sh   = r_sh;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_sh   = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_sh  = {r_sh[POLY_WIDTH-2:0], 1'b0};
            n_rem = (w_reduced < w_shifted) ? w_reduced : w_shifted;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(POLY_WIDTH - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_sh  <= n_sh;
        r_rem <= n_rem;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.zero = (r_rem == '0);

endmodule

FILE: rtl/gf2_irreducible_polynomial_sieve_unit.sv
// Sieve for irreducible polynomials over GF(2), integer encoded (bit k is the
// coefficient of x^k). A load item appends its value to the table; any item that
// arrives while the table is full only gets a FULL reply, and every reply waits until
// the output register is free. A find item walks candidates upward from the
// next-candidate register and tests each against the stored entries in table order
// with a bit-serial carry-less remainder unit; the test of a candidate stops at the
// first entry that divides it, and a candidate that survives all entries joins the
// table. A find is bounded by SEARCH_LIMIT candidates and by the top of the
// candidate range. The block holds one item at a time; a finished result sits in
// the output register while the block is free to take the next item.
module gf2_irreducible_polynomial_sieve_unit #(
    parameter int TABLE_DEPTH  = gfis_pkg::TABLE_DEPTH_DEF,
    parameter int POLY_WIDTH   = gfis_pkg::POLY_WIDTH_DEF,
    parameter int SEARCH_LIMIT = gfis_pkg::SEARCH_LIMIT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gfis_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gfis_pkg::t_out_item o_out
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LW = $clog2(SEARCH_LIMIT + 1);
    localparam int VW = gfis_pkg::VALUE_W;
    localparam int NW = gfis_pkg::COUNT_W;

    gfis_pkg::t_state    r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [POLY_WIDTH-1:0] r_next, n_next;
    logic [POLY_WIDTH-1:0] r_cand, n_cand;
    logic [LW-1:0]       r_left, n_left;
    logic [CW-1:0]       r_idx, n_idx;
    gfis_pkg::t_out_item r_res, n_res;
    gfis_pkg::t_out_item r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic                  w_in_acc;
    logic                  w_full;
    logic                  w_reply;
    logic [CW-1:0]         w_count_inc;
    logic [POLY_WIDTH+VW-1:0] w_load_ext;
    logic [POLY_WIDTH-1:0] w_load_v;
    logic [POLY_WIDTH+VW-1:0] w_load_out_ext;
    logic [POLY_WIDTH+VW-1:0] w_cand_out_ext;
    logic [CW+NW-1:0]      w_cnt_ext;
    logic [CW+NW-1:0]      w_cnt_inc_ext;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [POLY_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [POLY_WIDTH-1:0] ram_rdata;
    logic                  rem_start;
    gfis_pkg::t_rem_stat   rem_stat;

    assign o_in_ready = (r_state == gfis_pkg::S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_full     = (r_count >= CW'(TABLE_DEPTH));
    assign w_reply    = (r_state == gfis_pkg::S_REPLY) && (!r_out_valid || i_out_ready);

    assign w_count_inc    = r_count + 1'b1;
    assign w_load_ext     = {{POLY_WIDTH{1'b0}}, i_in.load_value};
    assign w_load_v       = w_load_ext[POLY_WIDTH-1:0];
    assign w_load_out_ext = {{VW{1'b0}}, w_load_v};
    assign w_cand_out_ext = {{VW{1'b0}}, r_cand};
    assign w_cnt_ext      = {{NW{1'b0}}, r_count};
    assign w_cnt_inc_ext  = {{NW{1'b0}}, w_count_inc};

    gfis_ram #(
        .WIDTH (POLY_WIDTH),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // The read data register holds the divisor steady for the whole division.
    gfis_rem #(
        .POLY_WIDTH (POLY_WIDTH)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_cand),
        .i_divisor  (ram_rdata),
        .o_stat     (rem_stat)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gfis_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (w_full || i_in.operation == gfis_pkg::OP_LOAD) begin
                        n_state = gfis_pkg::S_REPLY;
                    end else begin
                        n_state = gfis_pkg::S_CHECK;
                    end
                end
            end
            gfis_pkg::S_CHECK: begin
                if (r_idx == r_count) begin
                    n_state = gfis_pkg::S_REPLY;
                end else begin
                    n_state = gfis_pkg::S_DIV;
                end
            end
            gfis_pkg::S_DIV: begin
                if (rem_stat.done) begin
                    if (rem_stat.zero && (r_left == LW'(1) || r_cand == '1)) begin
                        n_state = gfis_pkg::S_REPLY;
                    end else begin
                        n_state = gfis_pkg::S_CHECK;
                    end
                end
            end
            gfis_pkg::S_REPLY: begin
                if (w_reply) begin
                    n_state = gfis_pkg::S_IDLE;
                end
            end
            default: n_state = gfis_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_next      = r_next;
        n_cand      = r_cand;
        n_left      = r_left;
        n_idx       = r_idx;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        ram_we      = 1'b0;
        ram_waddr   = r_count[AW-1:0];
        ram_wdata   = r_cand;
        ram_re      = 1'b0;
        rem_start   = 1'b0;
        unique case (r_state)
            gfis_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (w_full) begin
                        n_res.polynomial  = '0;
                        n_res.found       = 1'b0;
                        n_res.status      = gfis_pkg::ST_FULL;
                        n_res.entry_count = w_cnt_ext[NW-1:0];
                    end else if (i_in.operation == gfis_pkg::OP_LOAD) begin
                        ram_we            = 1'b1;
                        ram_wdata         = w_load_v;
                        n_count           = w_count_inc;
                        n_next            = w_load_v;
                        n_res.polynomial  = w_load_out_ext[VW-1:0];
                        n_res.found       = 1'b1;
                        n_res.status      = gfis_pkg::ST_OK;
                        n_res.entry_count = w_cnt_inc_ext[NW-1:0];
                    end else begin
                        n_cand = r_next;
                        n_left = LW'(SEARCH_LIMIT);
                        n_idx  = '0;
                    end
                end
            end
            gfis_pkg::S_CHECK: begin
                if (r_idx == r_count) begin
                    // The candidate survived every entry, so it joins the table.
                    ram_we            = 1'b1;
                    n_count           = w_count_inc;
                    n_next            = r_cand + 1'b1;
                    n_res.polynomial  = w_cand_out_ext[VW-1:0];
                    n_res.found       = 1'b1;
                    n_res.status      = gfis_pkg::ST_OK;
                    n_res.entry_count = w_cnt_inc_ext[NW-1:0];
                end else begin
                    ram_re    = 1'b1;
                    rem_start = 1'b1;
                end
            end
            gfis_pkg::S_DIV: begin
                if (rem_stat.done) begin
                    if (!rem_stat.zero) begin
                        n_idx = r_idx + 1'b1;
                    end else if (r_left == LW'(1) || r_cand == '1) begin
                        n_res.polynomial  = '0;
                        n_res.found       = 1'b0;
                        n_res.status      = gfis_pkg::ST_NONE;
                        n_res.entry_count = w_cnt_ext[NW-1:0];
                    end else begin
                        n_cand = r_cand + 1'b1;
                        n_left = r_left - 1'b1;
                        n_idx  = '0;
                    end
                end
            end
            gfis_pkg::S_REPLY: begin
                if (w_reply) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gfis_pkg::S_IDLE;
            r_count     <= '0;
            r_next      <= POLY_WIDTH'(2);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_next      <= n_next;
            r_out_valid <= n_out_valid;
        end
        r_cand <= n_cand;
        r_left <= n_left;
        r_idx  <= n_idx;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: rtl/gfis_checker.sv
module gfis_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input gfis_pkg::t_in_item  i_in,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input gfis_pkg::t_out_item o_out
);

    // A result waiting for the consumer stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed or dropped while stalled");

    // Only one item is in flight, so the block stops taking items after one.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("item accepted while another was in flight");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.found == (o_out.status == gfis_pkg::ST_OK)))
        else $error("found flag disagrees with status");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != gfis_pkg::ST_OK |-> o_out.polynomial == '0)
        else $error("error result carries a polynomial");

endmodule

bind gf2_irreducible_polynomial_sieve_unit gfis_checker u_gfis_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

FILE: tb/sv/sieve_result_monitor.sv
module sieve_result_monitor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  gfis_pkg::t_in_item  i_in,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  gfis_pkg::t_out_item i_out,
    output int                  o_fail_count,
    output int                  o_pending
);

    import gfis_pkg::*;

    logic [VALUE_W-1:0] poly_store [TABLE_DEPTH_DEF];
    int unsigned        stored_count;
    logic [VALUE_W-1:0] next_cand;
    t_out_item          predicted_polys [$];
    t_out_item          want;

    // Carry-less remainder of a by d; a zero divisor leaves a as it is.
    function automatic logic [VALUE_W-1:0] gf2_remainder(logic [VALUE_W-1:0] a,
                                                         logic [VALUE_W-1:0] d);
        int dd;
        dd = -1;
        for (int k = VALUE_W - 1; k >= 0; k--) begin
            if (d[k] && dd < 0) begin
                dd = k;
            end
        end
        if (dd < 0) begin
            return a;
        end
        for (int k = VALUE_W - 1; k >= dd; k--) begin
            if (a[k]) begin
                a = a ^ (d << (k - dd));
            end
        end
        return a;
    endfunction

    function automatic t_out_item sieve_next_result(t_in_item item);
        t_out_item          r;
        longint unsigned    tries;
        longint unsigned    headroom;
        logic [VALUE_W-1:0] cand;
        bit                 divisible;
        r = '0;
        if (stored_count >= TABLE_DEPTH_DEF) begin
            r.status = ST_FULL;
        end else if (item.operation == OP_LOAD) begin
            poly_store[stored_count] = item.load_value;
            stored_count++;
            next_cand = item.load_value;
            r.polynomial = item.load_value;
            r.found = 1'b1;
            r.status = ST_OK;
        end else begin
            // The search window stops at the top of the range instead of wrapping.
            headroom = 64'hFFFF_FFFF - longint'(next_cand);
            if (headroom >= longint'(SEARCH_LIMIT_DEF) - 1) begin
                tries = SEARCH_LIMIT_DEF;
            end else begin
                tries = headroom + 1;
            end
            r.status = ST_NONE;
            cand = next_cand;
            for (longint unsigned n = 0; n < tries; n++) begin
                divisible = 1'b0;
                for (int j = 0; j < stored_count && !divisible; j++) begin
                    if (gf2_remainder(cand, poly_store[j]) == '0) begin
                        divisible = 1'b1;
                    end
                end
                if (!divisible) begin
                    poly_store[stored_count] = cand;
                    stored_count++;
                    next_cand = cand + 1'b1;
                    r.polynomial = cand;
                    r.found = 1'b1;
                    r.status = ST_OK;
                    break;
                end
                cand = cand + 1'b1;
            end
        end
        r.entry_count = COUNT_W'(stored_count);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stored_count = 0;
            next_cand = 2;
            predicted_polys.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (predicted_polys.size() == 0) begin
                    $error("polynomial %h arrived with no item outstanding", i_out.polynomial);
                    o_fail_count++;
                end else begin
                    want = predicted_polys.pop_front();
                    if (i_out.polynomial !== want.polynomial) begin
                        $error("polynomial: expected %h, got %h",
                               want.polynomial, i_out.polynomial);
                        o_fail_count++;
                    end
                    if (i_out.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, i_out.found);
                        o_fail_count++;
                    end
                    if (i_out.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_out.status);
                        o_fail_count++;
                    end
                    if (i_out.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, i_out.entry_count);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predicted_polys = {predicted_polys, sieve_next_result(i_in)};
            end
        end
        o_pending = predicted_polys.size();
    end

endmodule

FILE: tb/sv/testbench.sv
module testbench;

    import gfis_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    int items_sent = 0;
    int results_seen = 0;
    int fail_count;
    int pending;
    bit quiet_tx = 1'b0;

    always #10 clk = ~clk;

    gf2_irreducible_polynomial_sieve_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    sieve_result_monitor result_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            results_seen <= results_seen + 1;
        end
    end

    // The receiver never stalls while results 60 to 99 come out.
    always @(posedge clk) begin
        if (results_seen >= 60 && results_seen < 100) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= 8);
        end
    end

    task automatic send_item(logic op, logic [VALUE_W-1:0] value);
        t_in_item item;
        item.operation = op;
        item.load_value = value;
        if (!quiet_tx && $urandom_range(0, 99) < 8) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (results_seen != items_sent) @(posedge clk);
    endtask

    initial begin
        logic [VALUE_W-1:0] value;
        logic               op;
        in_valid <= 1'b0;
        in_item <= '0;
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table, then a find that takes the top value and wraps the
        // next candidate to zero before x+1 is in the table.
        send_item(OP_FIND, $urandom);
        send_item(OP_LOAD, 32'hFFFF_FFFE);
        send_item(OP_FIND, $urandom);
        send_item(OP_LOAD, 32'h0000_0000);
        send_item(OP_LOAD, 32'h0000_0003);
        send_item(OP_FIND, $urandom);
        send_item(OP_FIND, $urandom);
        // A window of one candidate that divides itself finds nothing.
        send_item(OP_LOAD, 32'hFFFF_FFFF);
        send_item(OP_FIND, $urandom);
        send_item(OP_FIND, $urandom);
        send_item(OP_LOAD, 32'hAAAA_AAAA);
        send_item(OP_LOAD, 32'h5555_5555);
        send_item(OP_LOAD, 32'h8000_0000);
        send_item(OP_LOAD, 32'h0000_0002);
        repeat (4) send_item(OP_FIND, $urandom);
        wait_drained();

        // The next candidate is kept at 2 or above so that the unit
        // polynomial cannot enter the table here.
        for (int n = 0; n < 80; n++) begin
            quiet_tx = (n >= 30 && n < 55);
            if (n == 40) begin
                wait_drained();
            end
            op = ($urandom_range(0, 9) < 7) ? OP_FIND : OP_LOAD;
            if (op == OP_LOAD && $urandom_range(0, 1) == 0) begin
                value = $urandom_range(2, 255);
            end else begin
                value = $urandom;
            end
            if (op == OP_LOAD && value < 2) begin
                value = 2;
            end
            send_item(op, value);
        end

        // Once the unit polynomial is stored, every find would sweep the
        // whole search window, so the find follows a load near the top.
        send_item(OP_LOAD, 32'h0000_0001);
        send_item(OP_LOAD, 32'hFFFF_FFF0);
        send_item(OP_FIND, $urandom);

        in_valid <= 1'b0;
        while (results_seen != items_sent) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            if (pending != 0) begin
                $error("%0d predicted results never arrived", pending);
            end
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #1000000000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
